FILE: design/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package ptd_pkg;

   localparam int MAX_TASK_SLOTS = 16;
   localparam int SLOT_W  = (MAX_TASK_SLOTS > 1) ? $clog2(MAX_TASK_SLOTS) : 1;
   localparam int COUNT_W = $clog2(MAX_TASK_SLOTS + 1);

   localparam int TIME_W        = 64;
   localparam int PERIOD_W      = 32;
   localparam int TASK_INDEX_W  = 4;
   localparam int TASKS_REG_W   = 5;

   localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = 32'd100;

   typedef logic [SLOT_W-1:0]       slot_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [TIME_W-1:0]       time_type;
   typedef logic [PERIOD_W-1:0]     period_type;
   typedef logic [TASK_INDEX_W-1:0] task_index_type;
   typedef logic [TASKS_REG_W-1:0]  tasks_reg_type;

   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_ADD     = 2'd1,
      REQ_RESTART = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_TICK_SCAN,
      ST_RESTART_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic res_clear;
      logic scan_clear;
      logic scan_advance;
      logic tick_hit;
      logic add_exec;
      logic add_reject;
      logic restart_wr;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic total_zero;
      logic due;
      logic last;
      logic add_ok;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

FILE: design/ptd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module ptd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/ptd_ctrl.sv
// Controller state machine for the periodic task dispatcher.
// Depends on ptd_pkg; drives the datapath through cmd_type, reads status_type.
`default_nettype none

module ptd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_type,
   output logic                     req_stall,
   input  wire ptd_pkg::status_type status,
   output ptd_pkg::cmd_type         cmd
);

   ptd_pkg::state_type state_ff;
   ptd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  ptd_pkg::REQ_TICK: begin
                     state_in = status.total_zero ? ptd_pkg::ST_FINISH : ptd_pkg::ST_TICK_SCAN;
                  end
                  ptd_pkg::REQ_ADD: begin
                     state_in = ptd_pkg::ST_ADD;
                  end
                  ptd_pkg::REQ_RESTART: begin
                     state_in = status.total_zero ? ptd_pkg::ST_FINISH
                                                  : ptd_pkg::ST_RESTART_SCAN;
                  end
                  default: begin
                     state_in = ptd_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         ptd_pkg::ST_ADD: begin
            state_in = ptd_pkg::ST_FINISH;
         end
         ptd_pkg::ST_TICK_SCAN: begin
            if (status.due || status.last) begin
               state_in = ptd_pkg::ST_FINISH;
            end
         end
         ptd_pkg::ST_RESTART_SCAN: begin
            if (status.last) begin
               state_in = ptd_pkg::ST_FINISH;
            end
         end
         ptd_pkg::ST_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = ptd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.scan_clear = 1'b1;
            cmd.capture    = req_valid;
            cmd.res_clear  = req_valid;
         end
         ptd_pkg::ST_ADD: begin
            cmd.add_exec   = status.add_ok;
            cmd.add_reject = !status.add_ok;
         end
         ptd_pkg::ST_TICK_SCAN: begin
            cmd.tick_hit     = status.due;
            cmd.scan_advance = !status.due && !status.last;
         end
         ptd_pkg::ST_RESTART_SCAN: begin
            cmd.restart_wr   = 1'b1;
            cmd.scan_advance = !status.last;
         end
         ptd_pkg::ST_FINISH: begin
            cmd.rsp_load = !status.rsp_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/ptd_datapath.sv
// Datapath: request registers, task tables, scan index, due test, result
// and response registers. Depends on ptd_pkg and ptd_ram.
`default_nettype none

module ptd_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ptd_pkg::cmd_type                     cmd,
   output ptd_pkg::status_type                       status,
   input  wire logic [ptd_pkg::TIME_W-1:0]           req_now,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]         req_period,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]         csr_wr_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_dispatched,
   output logic      [ptd_pkg::TASK_INDEX_W-1:0]     rsp_task_index,
   output logic                                      rsp_add_rejected,
   output logic      [ptd_pkg::TASKS_REG_W-1:0]      rsp_tasks_registered
);

   ptd_pkg::time_type   now_ff;
   ptd_pkg::period_type period_ff;
   ptd_pkg::period_type min_period_ff, min_period_in;
   ptd_pkg::count_type  total_ff, total_in;
   ptd_pkg::slot_type   scan_idx_ff, scan_idx_in;
   ptd_pkg::slot_type   rd_addr;
   ptd_pkg::slot_type   add_slot;

   ptd_pkg::time_type   deadline_rd;
   ptd_pkg::period_type period_rd;
   ptd_pkg::time_type   sum_base;
   ptd_pkg::time_type   sum;
   logic [31:0]         diff;

   logic                dl_wr_en;
   ptd_pkg::slot_type   dl_wr_addr;
   ptd_pkg::time_type   dl_wr_data;

   logic                res_dispatched_ff, res_dispatched_in;
   ptd_pkg::slot_type   res_index_ff, res_index_in;
   logic                res_rejected_ff, res_rejected_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_dispatched_ff;
   ptd_pkg::task_index_type rsp_index_ff;
   logic                rsp_rejected_ff;
   ptd_pkg::tasks_reg_type  rsp_total_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff    <= req_now;
         period_ff <= req_period;
      end
   end

   assign min_period_in = csr_wr_en ? csr_wr_data : min_period_ff;
   assign total_in      = cmd.add_exec ? total_ff + ptd_pkg::count_type'(1) : total_ff;
   assign add_slot      = ptd_pkg::slot_type'(total_ff);

   // while the scan advances, the read address runs one slot ahead of the index whose data is on the ram outputs
   always_comb begin
      if (cmd.scan_clear) begin
         rd_addr = '0;
      end else if (cmd.scan_advance) begin
         rd_addr = scan_idx_ff + ptd_pkg::slot_type'(1);
      end else begin
         rd_addr = scan_idx_ff;
      end
   end
   assign scan_idx_in = rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= ptd_pkg::MIN_PERIOD_RESET;
         total_ff      <= '0;
         scan_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_period_ff <= min_period_in;
         total_ff      <= total_in;
         scan_idx_ff   <= scan_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   ptd_ram #(
      .WIDTH (ptd_pkg::PERIOD_W),
      .DEPTH (ptd_pkg::MAX_TASK_SLOTS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (cmd.add_exec),
      .wr_addr (add_slot),
      .wr_data (period_ff),
      .rd_addr (rd_addr),
      .rd_data (period_rd)
   );

   ptd_ram #(
      .WIDTH (ptd_pkg::TIME_W),
      .DEPTH (ptd_pkg::MAX_TASK_SLOTS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (dl_wr_addr),
      .wr_data (dl_wr_data),
      .rd_addr (rd_addr),
      .rd_data (deadline_rd)
   );

   // one adder serves both the deadline advance and the restart
   assign sum_base = cmd.tick_hit ? deadline_rd : now_ff;
   assign sum      = sum_base + ptd_pkg::time_type'(period_rd);

   assign dl_wr_en   = cmd.add_exec | cmd.tick_hit | cmd.restart_wr;
   assign dl_wr_addr = cmd.add_exec ? add_slot : scan_idx_ff;
   assign dl_wr_data = cmd.add_exec ? ptd_pkg::time_type'(period_ff) : sum;

   // due when the low 32 bits of now minus deadline are non-negative
   assign diff = now_ff[31:0] - deadline_rd[31:0];

   assign status.due        = !diff[31];
   assign status.last       = (ptd_pkg::count_type'(scan_idx_ff) + ptd_pkg::count_type'(1))
                              == total_ff;
   assign status.total_zero = (total_ff == '0);
   assign status.add_ok     = (total_ff != ptd_pkg::count_type'(ptd_pkg::MAX_TASK_SLOTS))
                              && (period_ff >= min_period_ff);
   assign status.rsp_busy   = rsp_valid_ff & rsp_stall;

   always_comb begin
      res_dispatched_in = res_dispatched_ff;
      res_index_in      = res_index_ff;
      res_rejected_in   = res_rejected_ff;
      if (cmd.res_clear) begin
         res_dispatched_in = 1'b0;
         res_index_in      = '0;
         res_rejected_in   = 1'b0;
      end else if (cmd.tick_hit) begin
         res_dispatched_in = 1'b1;
         res_index_in      = scan_idx_ff;
      end else if (cmd.add_exec) begin
         res_index_in      = add_slot;
      end else if (cmd.add_reject) begin
         res_rejected_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_dispatched_ff <= res_dispatched_in;
      res_index_ff      <= res_index_in;
      res_rejected_ff   <= res_rejected_in;
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_dispatched_ff <= res_dispatched_ff;
         rsp_index_ff      <= ptd_pkg::task_index_type'(res_index_ff);
         rsp_rejected_ff   <= res_rejected_ff;
         rsp_total_ff      <= ptd_pkg::tasks_reg_type'(total_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_dispatched       = rsp_dispatched_ff;
   assign rsp_task_index       = rsp_index_ff;
   assign rsp_add_rejected     = rsp_rejected_ff;
   assign rsp_tasks_registered = rsp_total_ff;

endmodule

`default_nettype wire

FILE: design/periodic_task_dispatcher.sv
// Periodic task dispatcher top level: controller plus datapath.
// Depends on ptd_pkg, ptd_ctrl, ptd_datapath and ptd_ram.
`default_nettype none

// One request is worked at a time. An add goes through the add state to the
// finish state, where the response is loaded. An unused type request, and a
// tick or a restart on an empty table, go straight to the finish state;
// otherwise a tick stops its scan at the first due task, and a restart
// visits every registered task. The scan reads one slot per cycle from the
// period and deadline tables, each a single read port RAM. A new request is
// taken as soon as the previous one is in the response register, even while
// that response is still stalled. min_period resets to 100; the user is to
// write it only while no request is in flight; the block does not check it.
module periodic_task_dispatcher (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_type,
   input  wire logic [ptd_pkg::TIME_W-1:0]           req_now,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]         req_period,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_dispatched,
   output logic      [ptd_pkg::TASK_INDEX_W-1:0]     rsp_task_index,
   output logic                                      rsp_add_rejected,
   output logic      [ptd_pkg::TASKS_REG_W-1:0]      rsp_tasks_registered,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]         csr_wr_data
);

   ptd_pkg::cmd_type    cmd;
   ptd_pkg::status_type status;

   ptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ptd_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_now              (req_now),
      .req_period           (req_period),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_dispatched       (rsp_dispatched),
      .rsp_task_index       (rsp_task_index),
      .rsp_add_rejected     (rsp_add_rejected),
      .rsp_tasks_registered (rsp_tasks_registered)
   );

endmodule

`default_nettype wire

FILE: design/ptd_checker.sv
// Port level checks for the periodic task dispatcher, bound to the top level.
// Depends on ptd_pkg.
`default_nettype none

module ptd_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic                                 rsp_dispatched,
   input wire logic [ptd_pkg::TASK_INDEX_W-1:0]     rsp_task_index,
   input wire logic                                 rsp_add_rejected,
   input wire logic [ptd_pkg::TASKS_REG_W-1:0]      rsp_tasks_registered
);

   // a stalled response stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight: the cycle after acceptance the input is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

   // a response is either a dispatch or a refused add, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_dispatched && rsp_add_rejected))
      else $error("dispatch and add refusal in one response");

   // a refused add reports index zero, and the count never exceeds the table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_add_rejected || rsp_task_index == '0) &&
                    (rsp_tasks_registered <= ptd_pkg::MAX_TASK_SLOTS))
      else $error("bad index or task count in response");

   // reset leaves no response pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_dispatched       (rsp_dispatched),
   .rsp_task_index       (rsp_task_index),
   .rsp_add_rejected     (rsp_add_rejected),
   .rsp_tasks_registered (rsp_tasks_registered)
);

`default_nettype wire

FILE: bench/dispatch_check_pkg.sv
// Scoreboard for the periodic task dispatcher bench: a task table predictor
// and the queue of expected responses. Depends on ptd_pkg.
package dispatch_check_pkg;
   import ptd_pkg::*;

   // request code the block leaves without effect
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic           dispatched;
      task_index_type task_index;
      logic           add_rejected;
      tasks_reg_type  tasks_registered;
   } dispatch_result_type;

   class dispatch_scoreboard;
      period_type          slot_period[MAX_TASK_SLOTS];
      time_type            slot_deadline[MAX_TASK_SLOTS];
      int unsigned         slot_count;
      period_type          min_period;
      dispatch_result_type expected_q[$];
      int unsigned         mismatch_count;

      function new();
         slot_count     = 0;
         min_period     = MIN_PERIOD_RESET;
         mismatch_count = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [1:0] kind, time_type now, period_type period);
         dispatch_result_type want;
         logic [31:0]         lag;
         logic                found;
         want  = '0;
         found = 1'b0;
         case (kind)
            REQ_TICK: begin
               for (int i = 0; i < slot_count; i++) begin
                  // only the low word of the lag counts, read as signed
                  lag = now[31:0] - slot_deadline[i][31:0];
                  if (!found && !lag[31]) begin
                     found            = 1'b1;
                     slot_deadline[i] = slot_deadline[i] + time_type'(slot_period[i]);
                     want.dispatched  = 1'b1;
                     want.task_index  = task_index_type'(i);
                  end
               end
            end
            REQ_ADD: begin
               if (slot_count < MAX_TASK_SLOTS && period >= min_period) begin
                  slot_period[slot_count]   = period;
                  slot_deadline[slot_count] = time_type'(period);
                  want.task_index           = task_index_type'(slot_count);
                  slot_count++;
               end else begin
                  want.add_rejected = 1'b1;
               end
            end
            REQ_RESTART: begin
               for (int i = 0; i < slot_count; i++)
                  slot_deadline[i] = now + time_type'(slot_period[i]);
            end
            default: ;
         endcase
         want.tasks_registered = tasks_reg_type'(slot_count);
         expected_q.push_back(want);
      endfunction

      function void flag(string what, dispatch_result_type want, dispatch_result_type seen);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%s: expected disp=%0d idx=%0d rej=%0d reg=%0d,",
                     what, want.dispatched, want.task_index, want.add_rejected,
                     want.tasks_registered,
                     " got disp=%0d idx=%0d rej=%0d reg=%0d",
                     seen.dispatched, seen.task_index,
                     seen.add_rejected, seen.tasks_registered);
      endfunction

      function void check_response(dispatch_result_type seen);
         dispatch_result_type want;
         if (expected_q.size() == 0) begin
            flag("response with no request outstanding", '0, seen);
            return;
         end
         want = expected_q.pop_front();
         if (seen.dispatched !== want.dispatched || seen.task_index !== want.task_index ||
             seen.add_rejected !== want.add_rejected ||
             seen.tasks_registered !== want.tasks_registered)
            flag("response mismatch", want, seen);
      endfunction
   endclass

endpackage

FILE: bench/tb_top.sv
// Top of the periodic task dispatcher bench: clock, reset, request and
// response drivers, monitor and watchdog. Depends on ptd_pkg and dispatch_check_pkg.
module tb_top;
   import ptd_pkg::*;
   import dispatch_check_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 40;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [1:0]      req_type = 2'd0;
   time_type        req_now = '0;
   period_type      req_period = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic            rsp_dispatched;
   task_index_type  rsp_task_index;
   logic            rsp_add_rejected;
   tasks_reg_type   rsp_tasks_registered;
   logic            csr_wr_en = 1'b0;
   period_type      csr_wr_data = '0;

   dispatch_scoreboard sb = new();
   logic        no_idle = 1'b0;
   logic        hold_off_req = 1'b0;
   time_type    wall_time = '0;
   int unsigned quiet_cycles = 0;

   periodic_task_dispatcher i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_now              (req_now),
      .req_period           (req_period),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_dispatched       (rsp_dispatched),
      .rsp_task_index       (rsp_task_index),
      .rsp_add_rejected     (rsp_add_rejected),
      .rsp_tasks_registered (rsp_tasks_registered),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin : monitor
      dispatch_result_type seen;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_type, req_now, req_period);
         if (rsp_valid && !rsp_stall) begin
            seen.dispatched       = rsp_dispatched;
            seen.task_index       = rsp_task_index;
            seen.add_rejected     = rsp_add_rejected;
            seen.tasks_registered = rsp_tasks_registered;
            sb.check_response(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : receiver
      int unsigned wait_n;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            wait_n = LONG_HOLD;
         end else begin
            wait_n = no_idle ? 0 : $urandom_range(0, 17);
         end
         if (wait_n != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // returns at the edge where the request is taken
   task automatic send(input logic [1:0] kind, input time_type now, input period_type period);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_now    <= now;
      req_period <= period;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_min_period(input period_type value);
      settle();
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= value;
      sb.min_period  = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_request(input int unsigned add_cap);
      int unsigned pick;
      time_type    now;
      period_type  period;
      logic [1:0]  kind;
      pick   = $urandom_range(0, 99);
      now    = {$urandom, $urandom};
      period = $urandom;
      if (pick < 60) begin
         kind = REQ_TICK;
         if (pick >= 4) begin
            wall_time = wall_time + time_type'($urandom_range(0, 400));
            now       = wall_time;
         end
      end else if (pick < 75) begin
         kind = REQ_ADD;
         if (sb.slot_count >= add_cap)
            kind = REQ_TICK;
         else if (pick < 71)
            period = sb.min_period + period_type'($urandom_range(0, 2000));
         else if (pick < 73)
            period = period_type'($urandom_range(0, sb.min_period));
      end else if (pick < 88) begin
         kind = REQ_RESTART;
         // jump the time base somewhere far off now and then
         if (pick < 80)
            wall_time = {$urandom, $urandom};
         now = wall_time;
      end else if (pick < 93) begin
         kind = REQ_UNUSED;
      end else begin
         kind = REQ_TICK;
      end
      send(kind, now, period);
   endtask

   initial begin : stimulus
      int unsigned fill;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, unused code, refused and accepted adds
      send(REQ_TICK, '0, $urandom);
      send(REQ_RESTART, '1, $urandom);
      send(REQ_UNUSED, {$urandom, $urandom}, $urandom);
      send(REQ_ADD, {$urandom, $urandom}, 32'd99);
      send(REQ_ADD, {$urandom, $urandom}, 32'd0);
      send(REQ_ADD, {$urandom, $urandom}, 32'd100);
      send(REQ_ADD, {$urandom, $urandom}, 32'd150);
      // one short of due, then priority order
      send(REQ_TICK, 64'd99, $urandom);
      send(REQ_TICK, 64'd150, $urandom);
      send(REQ_TICK, 64'd150, $urandom);
      send(REQ_TICK, 64'd150, $urandom);
      // deadlines wrap past the top of the time range
      send(REQ_RESTART, 64'hFFFF_FFFF_FFFF_FFC0, $urandom);
      send(REQ_TICK, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
      send(REQ_TICK, 64'h0000_0000_8000_0023, $urandom);
      send(REQ_TICK, 64'h0000_0000_8000_0088, $urandom);
      // zero lag with the high word far off
      send(REQ_TICK, 64'hFFFF_FFFF_0000_0088, $urandom);
      send(REQ_UNUSED, '1, '1);
      send(REQ_ADD, '0, 32'hFFFF_FFFF);

      set_min_period(32'hFFFF_FFFF);
      send(REQ_ADD, {$urandom, $urandom}, 32'hFFFF_FFFE);
      send(REQ_ADD, {$urandom, $urandom}, 32'hFFFF_FFFF);

      set_min_period(32'd200);
      for (int n = 0; n < 240; n++) begin
         if (n % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if (n == 100)
            hold_off_req = 1'b1;
         if (n == 170)
            settle();
         random_request(12);
      end

      // fill the table, zero period task last, then adds against a full table
      set_min_period(32'd0);
      fill = sb.slot_count;
      while (fill < MAX_TASK_SLOTS - 1) begin
         send(REQ_ADD, {$urandom, $urandom}, period_type'($urandom_range(1, 3000)));
         fill++;
      end
      send(REQ_ADD, {$urandom, $urandom}, 32'd0);
      send(REQ_ADD, {$urandom, $urandom}, 32'd5);
      for (int n = 0; n < 150; n++) begin
         if (n % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         random_request(MAX_TASK_SLOTS + 1);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
